### rtl/cetm_pkg.sv
package cetm_pkg;

   // default text store sizes
   localparam int EXPR_BUFFER  = 64;
   localparam int FIELD_BUFFER = 32;

   // token kinds
   localparam logic [1:0] KIND_PLAIN = 2'd0;
   localparam logic [1:0] KIND_RANGE = 2'd1;
   localparam logic [1:0] KIND_STEP  = 2'd2;

   // token parse phases
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_STAR  = 4'd1;
   localparam logic [3:0] PH_WS1   = 4'd2;
   localparam logic [3:0] PH_SIGN1 = 4'd3;
   localparam logic [3:0] PH_DIG1  = 4'd4;
   localparam logic [3:0] PH_WS2   = 4'd5;
   localparam logic [3:0] PH_SIGN2 = 4'd6;
   localparam logic [3:0] PH_DIG2  = 4'd7;
   localparam logic [3:0] PH_FAIL  = 4'd8;
   localparam logic [3:0] PH_GOT2  = 4'd9;

   // whole-field shape tracking: "*", "*/", "*/1", anything else
   localparam logic [2:0] SHAPE_NONE  = 3'd0;
   localparam logic [2:0] SHAPE_STAR  = 3'd1;
   localparam logic [2:0] SHAPE_SLASH = 3'd2;
   localparam logic [2:0] SHAPE_ONE   = 3'd3;
   localparam logic [2:0] SHAPE_OTHER = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_DASH  = 8'd45;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_ONE   = 8'd49;

   localparam logic [2:0] NUM_FIELDS   = 3'd5;
   localparam logic [4:0] SUNDAY_VALUE = 5'd7;
   localparam int         TIME_W       = 6;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day_of_month;
      logic [3:0] month_index;
      logic [2:0] weekday;
   } req_type;

   typedef struct packed {
      logic matched;
      logic malformed;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  field_index;
      logic [1:0]  kind;
      logic [15:0] first;
      logic        first_neg;
      logic [15:0] second;
      logic        second_neg;
      logic [3:0]  phase;
      logic [2:0]  shape;
      logic        field_hit;
      logic        all_hit;
      logic        text_ended;
   } parse_type;

   localparam parse_type PARSE_CLEAR = '{
      field_index: 3'd0, kind: KIND_PLAIN, first: 16'd0, first_neg: 1'b0,
      second: 16'd0, second_neg: 1'b0, phase: PH_IDLE, shape: SHAPE_NONE,
      field_hit: 1'b0, all_hit: 1'b1, text_ended: 1'b0};

   function automatic logic is_ws(logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   // decimal accumulate, saturating at 65535
   function automatic logic [15:0] acc(logic [15:0] m, logic [7:0] c);
      logic [19:0] r;
      r = ({4'd0, m} << 3) + ({4'd0, m} << 1) + {16'd0, c[3:0]};
      return (r > 20'd65535) ? 16'hffff : r[15:0];
   endfunction

   function automatic parse_type clear_token(parse_type s);
      parse_type r;
      r = s;
      r.phase      = PH_IDLE;
      r.kind       = KIND_PLAIN;
      r.first      = 16'd0;
      r.first_neg  = 1'b0;
      r.second     = 16'd0;
      r.second_neg = 1'b0;
      return r;
   endfunction

   function automatic logic step_pending(parse_type s);
      return (s.phase != PH_IDLE) && (s.kind == KIND_STEP);
   endfunction

   function automatic parse_type end_token(parse_type s, logic [TIME_W-1:0] v,
                                           logic step_hit);
      parse_type          r;
      logic signed [17:0] sv;
      logic signed [17:0] lo;
      logic signed [17:0] hi;
      r  = s;
      sv = {12'd0, v};
      lo = s.first_neg ? -$signed({2'd0, s.first}) : $signed({2'd0, s.first});
      hi = s.second_neg ? -$signed({2'd0, s.second}) : $signed({2'd0, s.second});
      case (s.kind)
         KIND_STEP: begin
            if (!s.first_neg && s.first != 16'd0 && step_hit) r.field_hit = 1'b1;
         end
         KIND_RANGE: begin
            if ((s.phase == PH_DIG2 || s.phase == PH_GOT2) && sv >= lo && sv <= hi)
               r.field_hit = 1'b1;
         end
         default: begin
            if (lo == sv) r.field_hit = 1'b1;
         end
      endcase
      return clear_token(r);
   endfunction

   function automatic parse_type end_field(parse_type s, logic [TIME_W-1:0] v,
                                           logic step_hit);
      parse_type r;
      r = s;
      if (r.phase != PH_IDLE) r = end_token(r, v, step_hit);
      if (r.shape == SHAPE_STAR || r.shape == SHAPE_ONE) r.field_hit = 1'b1;
      if (!r.field_hit) r.all_hit = 1'b0;
      r.field_index = r.field_index + 3'd1;
      r.shape       = SHAPE_NONE;
      return r;
   endfunction

   function automatic parse_type token_char(parse_type s, logic [7:0] c);
      parse_type  r;
      logic [3:0] ph;
      r = s;
      if (c == CH_DASH && r.kind != KIND_STEP) r.kind = KIND_RANGE;
      if (r.phase == PH_IDLE && c == CH_STAR) begin
         r.phase = PH_STAR;
      end else begin
         ph = (r.phase == PH_IDLE) ? PH_WS1 : r.phase;
         r.phase = ph;
         case (ph)
            PH_STAR: begin
               if (c == CH_SLASH) begin
                  r.kind  = KIND_STEP;
                  r.phase = PH_WS1;
               end else r.phase = PH_FAIL;
            end
            PH_WS1: begin
               if (is_ws(c)) begin
                  r.phase = PH_WS1;
               end else if (c == CH_PLUS || c == CH_DASH) begin
                  r.first_neg = (c == CH_DASH);
                  r.phase     = PH_SIGN1;
               end else if (is_digit(c)) begin
                  r.first = {12'd0, c[3:0]};
                  r.phase = PH_DIG1;
               end else r.phase = PH_FAIL;
            end
            PH_SIGN1: begin
               if (is_digit(c)) begin
                  r.first = {12'd0, c[3:0]};
                  r.phase = PH_DIG1;
               end else r.phase = PH_FAIL;
            end
            PH_DIG1: begin
               if (is_digit(c)) r.first = acc(r.first, c);
               else r.phase = (c == CH_DASH) ? PH_WS2 : PH_FAIL;
            end
            PH_WS2: begin
               if (is_ws(c)) begin
                  r.phase = PH_WS2;
               end else if (c == CH_PLUS || c == CH_DASH) begin
                  r.second_neg = (c == CH_DASH);
                  r.phase      = PH_SIGN2;
               end else if (is_digit(c)) begin
                  r.second = {12'd0, c[3:0]};
                  r.phase  = PH_DIG2;
               end else r.phase = PH_FAIL;
            end
            PH_SIGN2: begin
               if (is_digit(c)) begin
                  r.second = {12'd0, c[3:0]};
                  r.phase  = PH_DIG2;
               end else r.phase = PH_FAIL;
            end
            PH_DIG2: begin
               if (is_digit(c)) r.second = acc(r.second, c);
               else r.phase = PH_GOT2;
            end
            default: begin
               r.phase = ph;
            end
         endcase
      end
      return r;
   endfunction

endpackage

### rtl/cron_expression_time_matcher.sv
// cron expression time matcher
//
// req channel: one character of a five-field cron expression per item, with
// the current time; last marks the final character. The time is captured on
// the first character of each expression. rsp channel: one item (matched,
// malformed) for each item that carries last, none for the others.
//
// ST_IDLE accepts and registers each character; ST_EXEC then runs it through
// the field/token parser. when the character closes a step token (star, slash,
// n), a shared restoring remainder unit runs one bit per cycle over the 6-bit
// time value in ST_MOD, then hands back to ST_EXEC. req_stall is high while
// an item is in flight.
//
// reset clears the parser and time capture and empties the result register.
// the result register lets the next characters be taken while a result waits;
// an item with last waits in the parser until a stalled result is taken.
module cron_expression_time_matcher #(
   parameter int EXPR_BUFFER  = cetm_pkg::EXPR_BUFFER,
   parameter int FIELD_BUFFER = cetm_pkg::FIELD_BUFFER
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cetm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cetm_pkg::rsp_type rsp_data
);

   localparam int EL_W = $clog2(EXPR_BUFFER + 1);
   localparam int FL_W = $clog2(FIELD_BUFFER);
   localparam int TW   = cetm_pkg::TIME_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_MOD  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   cetm_pkg::req_type    item_ff;
   cetm_pkg::parse_type  parse_ff, parse_in;
   logic [EL_W-1:0]      elen_ff, elen_in;
   logic [FL_W-1:0]      flen_ff, flen_in;
   logic [TW-1:0]        time_ff [5];
   cetm_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   // remainder unit
   logic [TW-1:0]        rem_ff, dvd_ff, rem_next;
   logic [15:0]          div_ff;
   logic [2:0]           cnt_ff;
   logic                 mod_done_ff, mod_hit_ff;
   logic [TW:0]          shifted;

   logic [TW-1:0]        cur_time;
   logic                 step_seen;
   logic [15:0]          step_n;
   logic                 accept, commit, out_busy;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   // time value of the field being parsed
   always_comb begin
      case (parse_ff.field_index)
         3'd0: cur_time = time_ff[0];
         3'd1: cur_time = time_ff[1];
         3'd2: cur_time = time_ff[2];
         3'd3: cur_time = time_ff[3];
         3'd4: cur_time = time_ff[4];
         default: cur_time = '0;
      endcase
   end

   // one character through the parser
   always_comb begin
      logic [7:0] c;
      c         = item_ff.ch;
      parse_in  = parse_ff;
      flen_in   = flen_ff;
      step_seen = 1'b0;
      step_n    = 16'd0;
      rsp_in    = rsp_ff;
      if (elen_ff < EL_W'(EXPR_BUFFER - 1) && !parse_in.text_ended) begin
         if (c == cetm_pkg::CH_NUL) begin
            parse_in.text_ended = 1'b1;
         end else if (c == cetm_pkg::CH_SPACE) begin
            if (parse_in.shape != cetm_pkg::SHAPE_NONE) begin
               if (cetm_pkg::step_pending(parse_in)) begin
                  step_seen = 1'b1;
                  step_n    = parse_in.first;
               end
               parse_in = cetm_pkg::end_field(parse_in, cur_time, mod_hit_ff);
            end
         end else if (parse_in.shape != cetm_pkg::SHAPE_NONE ||
                      parse_in.field_index < cetm_pkg::NUM_FIELDS) begin
            if (parse_in.shape == cetm_pkg::SHAPE_NONE) begin
               flen_in            = '0;
               parse_in.field_hit = 1'b0;
               parse_in           = cetm_pkg::clear_token(parse_in);
            end
            case (parse_in.shape)
               cetm_pkg::SHAPE_NONE: parse_in.shape = (c == cetm_pkg::CH_STAR) ?
                  cetm_pkg::SHAPE_STAR : cetm_pkg::SHAPE_OTHER;
               cetm_pkg::SHAPE_STAR: parse_in.shape = (c == cetm_pkg::CH_SLASH) ?
                  cetm_pkg::SHAPE_SLASH : cetm_pkg::SHAPE_OTHER;
               cetm_pkg::SHAPE_SLASH: parse_in.shape = (c == cetm_pkg::CH_ONE) ?
                  cetm_pkg::SHAPE_ONE : cetm_pkg::SHAPE_OTHER;
               default: parse_in.shape = cetm_pkg::SHAPE_OTHER;
            endcase
            // long fields stop feeding the token parser
            if (flen_in < FL_W'(FIELD_BUFFER - 1)) begin
               flen_in = flen_in + FL_W'(1);
               if (c == cetm_pkg::CH_COMMA) begin
                  if (parse_in.phase != cetm_pkg::PH_IDLE) begin
                     if (cetm_pkg::step_pending(parse_in)) begin
                        step_seen = 1'b1;
                        step_n    = parse_in.first;
                     end
                     parse_in = cetm_pkg::end_token(parse_in, cur_time, mod_hit_ff);
                  end
               end else begin
                  parse_in = cetm_pkg::token_char(parse_in, c);
               end
            end
         end
      end
      elen_in = (elen_ff < EL_W'(EXPR_BUFFER)) ? elen_ff + EL_W'(1) : elen_ff;
      if (item_ff.last) begin
         if (parse_in.shape != cetm_pkg::SHAPE_NONE) begin
            if (cetm_pkg::step_pending(parse_in)) begin
               step_seen = 1'b1;
               step_n    = parse_in.first;
            end
            parse_in = cetm_pkg::end_field(parse_in, cur_time, mod_hit_ff);
         end
         rsp_in.malformed = parse_in.field_index < cetm_pkg::NUM_FIELDS;
         rsp_in.matched   = !rsp_in.malformed && parse_in.all_hit;
         parse_in         = cetm_pkg::PARSE_CLEAR;
         elen_in          = '0;
         flen_in          = '0;
      end
   end

   // restoring remainder step, one dividend bit per cycle
   assign shifted  = {rem_ff, dvd_ff[TW-1]};
   assign rem_next = ({9'd0, shifted} >= div_ff) ?
                     TW'(shifted - div_ff[TW:0]) : shifted[TW-1:0];

   assign commit = (state_ff == ST_EXEC) && !(step_seen && !mod_done_ff) &&
                   !(item_ff.last && out_busy);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            if (step_seen && !mod_done_ff) state_in = ST_MOD;
            else if (commit) state_in = ST_IDLE;
         end
         ST_MOD: if (cnt_ff == 3'd0) state_in = ST_EXEC;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         parse_ff     <= cetm_pkg::PARSE_CLEAR;
         elen_ff      <= '0;
         flen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mod_done_ff  <= 1'b0;
         mod_hit_ff   <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < 5; i++) time_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         // a new result replaces the one taken at this edge
         if (commit && item_ff.last) begin
            rsp_ff       <= rsp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            item_ff     <= req_data;
            mod_done_ff <= 1'b0;
            if (elen_ff == '0) begin
               time_ff[0] <= req_data.minute;
               time_ff[1] <= {1'b0, req_data.hour};
               time_ff[2] <= {1'b0, req_data.day_of_month};
               time_ff[3] <= {2'b0, req_data.month_index} + TW'(1);
               time_ff[4] <= (req_data.weekday == 3'd0) ?
                             TW'(cetm_pkg::SUNDAY_VALUE) : {3'b0, req_data.weekday};
            end
         end
         if (state_ff == ST_EXEC && step_seen && !mod_done_ff) begin
            rem_ff <= '0;
            dvd_ff <= cur_time;
            div_ff <= step_n;
            cnt_ff <= 3'(TW - 1);
         end
         if (state_ff == ST_MOD) begin
            rem_ff <= rem_next;
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               mod_done_ff <= 1'b1;
               mod_hit_ff  <= (rem_next == '0);
            end
         end
         if (commit) begin
            parse_ff <= parse_in;
            elen_ff  <= elen_in;
            flen_ff  <= flen_in;
         end
      end
   end

   a_mod_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && cnt_ff == 3'd0) |=> (state_ff == ST_EXEC && mod_done_ff))
      else $error("remainder unit did not hand back to the parser");

   a_step_runs_unit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && step_seen && !mod_done_ff) |=> (state_ff == ST_MOD))
      else $error("step token closed without a remainder pass");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(commit && item_ff.last))
      else $error("result raised without a final character");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.matched && rsp_ff.malformed))
      else $error("result both matched and malformed");

endmodule
